// ===== design/isc_pkg.sv =====
package isc_pkg;

  localparam int Depth = 16;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_TOP     = 3'd2,
    OP_DIV     = 3'd3,
    OP_PRIME   = 3'd4,
    OP_REPLACE = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               prime;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_TOP, S_RD_SEC, S_DECIDE, S_DIV_RUN, S_DIV_WB,
    S_PR_CHK, S_PR_SQ, S_PR_DIV, S_RESULT, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_top;      // latch memory read data as the top word
    logic load_sec;      // latch memory read data as the second word
    logic div_start;     // start a signed divide of top by second
    logic pr_init;       // set trial divisor to 2
    logic pr_sq;         // register trial divisor squared
    logic pr_start;      // start top mod trial divisor
    logic pr_next;       // advance trial divisor
    logic mem_we;        // write wdata at waddr
    logic wsel_div;      // write quotient instead of the operand
    logic wr_top;        // write the operand over the top entry
    logic [1:0] rsel;    // read address: 0 top, 1 second, 2 top
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_zero;
    logic pr_small;      // top is negative or below 2
    logic pr_over;       // trial divisor squared exceeds top
    logic pr_rem_zero;
  } stat_t;

endpackage

// ===== design/integer_stack_calculator.sv =====
// Push, pop, top and replace go through the result state to the output state.
// Divide runs the 32-step restoring divider; a zero divisor skips it.
// A prime test runs one divide of the top per trial divisor, up to some 46000 divisors.
// One item at a time; the next transfer in waits for the result transfer.
// Reset (rst, synchronous, active high) empties the stack and sets depth_limit to 16.
module integer_stack_calculator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output isc_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  // Every configuration transfer is taken; the limit should only change while
  // no item is in flight.
  logic [4:0] depth_limit;
  logic [isc_pkg::CntW-1:0] fill;
  logic [1:0] status;
  logic prime, have_top;
  logic [31:0] rd_word;
  isc_pkg::cmd_t cmd;
  isc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) depth_limit <= 5'd16;
    else if (cfg_valid) depth_limit <= cfg_data;
  end

  isc_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .opcode(in_data.opcode), .limit(depth_limit),
    .out_valid, .out_ready, .status, .prime, .have_top,
    .fill, .cmd, .stat
  );

  isc_datapath u_dp (
    .clk, .rst, .cmd, .fill, .operand(in_data.operand), .stat, .rd_word
  );

  // The memory read of the top is issued in the result state and held for output.
  always_comb begin
    out_data.status = status;
    out_data.data   = have_top ? rd_word : 32'hFFFF_FFFF;
    out_data.prime  = prime;
  end

endmodule

// ===== design/isc_datapath.sv =====
module isc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  isc_pkg::cmd_t               cmd,
  input  logic [isc_pkg::CntW-1:0]    fill,
  input  logic signed [31:0]          operand,
  output isc_pkg::stat_t              stat,
  output logic [31:0]                 rd_word
);

  logic [31:0] mem [isc_pkg::Depth];
  logic [31:0] top_w, sec_w, rdata;
  logic [isc_pkg::PtrW-1:0] raddr, waddr;
  logic [isc_pkg::CntW-1:0] roff;

  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        busy, neg_q;
  logic [32:0] trial;
  logic [15:0] pdiv;
  logic [32:0] psq;

  assign rd_word = rdata;

  always_comb begin
    case (cmd.rsel)
      2'd0:    roff = fill - isc_pkg::CntW'(1);
      2'd1:    roff = fill - isc_pkg::CntW'(2);
      default: roff = fill - isc_pkg::CntW'(1);
    endcase
    raddr = roff[isc_pkg::PtrW-1:0];
    if (cmd.wsel_div || cmd.wr_top) waddr = roff[isc_pkg::PtrW-1:0];
    else waddr = fill[isc_pkg::PtrW-1:0];
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.mem_we) mem[waddr] <= cmd.wsel_div ? (neg_q ? -quo : quo) : operand;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_top) top_w <= rdata;
    if (cmd.load_sec) sec_w <= rdata;
    if (cmd.pr_sq) psq <= 33'(pdiv) * 33'(pdiv);
    if (cmd.pr_init) pdiv <= 16'd2;
    else if (cmd.pr_next) pdiv <= pdiv + 16'd1;
  end

  // One quotient bit per cycle.
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      busy  <= 1'b0;
    end else if (cmd.div_start) begin
      rem   <= '0;
      quo   <= top_w[31] ? -top_w : top_w;
      dvs   <= sec_w[31] ? -sec_w : sec_w;
      neg_q <= top_w[31] ^ sec_w[31];
      cnt   <= 6'd32;
      busy  <= 1'b1;
    end else if (cmd.pr_start) begin
      rem   <= '0;
      quo   <= top_w;
      dvs   <= {16'd0, pdiv};
      neg_q <= 1'b0;
      cnt   <= 6'd32;
      busy  <= 1'b1;
    end else if (busy) begin
      if (trial[32]) rem <= {rem[30:0], quo[31]};
      else rem <= trial[31:0];
      quo  <= {quo[30:0], ~trial[32]};
      cnt  <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
    end
  end

  always_comb begin
    stat.div_done    = !busy;
    stat.div_zero    = (sec_w == 32'd0);
    stat.pr_small    = top_w[31] || (top_w < 32'd2);
    stat.pr_over     = psq > {1'b0, top_w};
    stat.pr_rem_zero = (rem == 32'd0);
  end

endmodule

// ===== design/isc_control.sv =====
module isc_control (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               opcode,
  input  logic [4:0]               limit,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic                     prime,
  output logic                     have_top,
  output logic [isc_pkg::CntW-1:0] fill,
  output isc_pkg::cmd_t            cmd,
  input  isc_pkg::stat_t           stat
);

  isc_pkg::state_t state, state_next;
  logic [2:0] op;
  logic [1:0] status_next;
  logic prime_next;
  logic [isc_pkg::CntW-1:0] fill_next;
  logic [isc_pkg::CntW-1:0] lim;
  logic issued;

  always_comb begin
    if (limit == 5'd0) lim = isc_pkg::CntW'(1);
    else if (32'(limit) > isc_pkg::Depth) lim = isc_pkg::CntW'(isc_pkg::Depth);
    else lim = isc_pkg::CntW'(limit);
  end

  assign in_ready  = (state == isc_pkg::S_IDLE);
  assign out_valid = (state == isc_pkg::S_OUT);
  assign have_top  = (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= isc_pkg::S_IDLE;
      fill   <= '0;
      status <= isc_pkg::ST_OK;
      prime  <= 1'b0;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      status <= status_next;
      prime  <= prime_next;
      issued <= cmd.pr_start;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) op <= opcode;
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    status_next = status;
    prime_next  = prime;
    cmd         = '0;
    case (state)
      isc_pkg::S_IDLE: begin
        if (in_valid) begin
          status_next = isc_pkg::ST_OK;
          prime_next  = 1'b0;
          state_next  = isc_pkg::S_RESULT;
          case (opcode)
            isc_pkg::OP_PUSH: begin
              if (fill >= lim) status_next = isc_pkg::ST_FULL;
              else begin
                cmd.mem_we = 1'b1;
                fill_next  = fill + isc_pkg::CntW'(1);
              end
            end
            isc_pkg::OP_POP: begin
              if (fill == '0) status_next = isc_pkg::ST_EMPTY;
              else fill_next = fill - isc_pkg::CntW'(1);
            end
            isc_pkg::OP_DIV: begin
              if (fill < isc_pkg::CntW'(2)) status_next = isc_pkg::ST_EMPTY;
              else state_next = isc_pkg::S_RD_TOP;
            end
            isc_pkg::OP_PRIME: begin
              if (fill == '0) status_next = isc_pkg::ST_EMPTY;
              else state_next = isc_pkg::S_RD_TOP;
            end
            isc_pkg::OP_REPLACE: begin
              if (fill == '0) status_next = isc_pkg::ST_EMPTY;
              else begin
                cmd.mem_we = 1'b1;
                cmd.wr_top = 1'b1;
              end
            end
            default: begin
              if (fill == '0) status_next = isc_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      // Read issued in this state returns next cycle.
      isc_pkg::S_RD_TOP: begin
        cmd.rsel   = 2'd0;
        state_next = isc_pkg::S_RD_SEC;
      end
      isc_pkg::S_RD_SEC: begin
        cmd.load_top = 1'b1;
        cmd.rsel     = 2'd1;
        cmd.pr_init  = 1'b1;
        state_next   = (op == isc_pkg::OP_DIV) ? isc_pkg::S_DECIDE : isc_pkg::S_PR_CHK;
      end
      isc_pkg::S_DECIDE: begin
        cmd.load_sec = 1'b1;
        state_next   = isc_pkg::S_DIV_RUN;
        cmd.rsel     = 2'd1;
      end
      isc_pkg::S_DIV_RUN: begin
        cmd.rsel = 2'd1;
        if (stat.div_zero) begin
          status_next = isc_pkg::ST_DIVZERO;
          state_next  = isc_pkg::S_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = isc_pkg::S_DIV_WB;
        end
      end
      isc_pkg::S_DIV_WB: begin
        cmd.rsel = 2'd1;
        if (stat.div_done) begin
          cmd.mem_we   = 1'b1;
          cmd.wsel_div = 1'b1;
          fill_next    = fill - isc_pkg::CntW'(1);
          state_next   = isc_pkg::S_RESULT;
        end
      end
      isc_pkg::S_PR_CHK: begin
        if (stat.pr_small) state_next = isc_pkg::S_RESULT;
        else begin
          cmd.pr_sq  = 1'b1;
          state_next = isc_pkg::S_PR_SQ;
        end
      end
      isc_pkg::S_PR_SQ: begin
        if (stat.pr_over) begin
          prime_next = 1'b1;
          state_next = isc_pkg::S_RESULT;
        end else begin
          cmd.pr_start = 1'b1;
          state_next   = isc_pkg::S_PR_DIV;
        end
      end
      isc_pkg::S_PR_DIV: begin
        if (!issued && stat.div_done) begin
          if (stat.pr_rem_zero) state_next = isc_pkg::S_RESULT;
          else begin
            cmd.pr_next = 1'b1;
            state_next  = isc_pkg::S_PR_CHK;
          end
        end
      end
      isc_pkg::S_RESULT: begin
        cmd.rsel   = 2'd0;
        state_next = isc_pkg::S_OUT;
      end
      isc_pkg::S_OUT: begin
        if (out_ready) state_next = isc_pkg::S_IDLE;
      end
      default: state_next = isc_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== design/isc_checker.sv =====
module isc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input isc_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("new item taken with result pending");

  a_prime_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.prime |-> out_data.status == isc_pkg::ST_OK)
    else $error("prime flag with failing status");

  a_prime_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.prime |-> out_data.data > 32'sd1)
    else $error("prime flag on a value below 2");

endmodule

bind integer_stack_calculator isc_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
